[rtl/core/wps_pkg.sv]
package wps_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic               out_kind;
        logic signed [15:0] sample;
        logic               chunk_start;
        logic [2:0]         status;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [30:0]        frame_count;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] format;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
    } fmt_t;

    typedef struct packed {
        logic               has_smp;
        logic signed [15:0] sample;
        logic               chunk_start;
        logic               smp_last;
        logic               has_rep;
        logic [2:0]         status;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [30:0]        numer;
    } cmd_t;

    localparam logic [31:0] FMT_ID    = 32'h2074_6d66;
    localparam logic [31:0] DATA_ID   = 32'h6174_6164;
    localparam logic [31:0] FMT_MIN   = 32'd16;
    localparam logic [3:0]  HDR_LAST  = 4'd11;
    localparam logic [2:0]  CHDR_LAST = 3'd7;
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] BITS_16   = 16'd16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_RIFF   = 3'd1;
    localparam logic [2:0] ST_SHORT_FMT = 3'd2;
    localparam logic [2:0] ST_MISSING   = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;
    localparam logic [2:0] ST_NOT_16BIT = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;
    localparam logic [2:0] ST_ZERO_CH   = 3'd7;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int QUO_W = 31;
    localparam int CNT_W = $clog2(QUO_W);

    function automatic logic [7:0] sig_byte(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'h52;
            4'd1:    r = 8'h49;
            4'd2:    r = 8'h46;
            4'd3:    r = 8'h46;
            4'd8:    r = 8'h57;
            4'd9:    r = 8'h41;
            4'd10:   r = 8'h56;
            4'd11:   r = 8'h45;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/wps_front.sv]
module wps_front import wps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     accept,
    input  in_item_t item,
    output logic     push,
    output cmd_t     cmd
);

    typedef enum logic [5:0] {
        PH_HDR      = 6'b000001,
        PH_CHDR     = 6'b000010,
        PH_BODY     = 6'b000100,
        PH_PAD      = 6'b001000,
        PH_BADSIG   = 6'b010000,
        PH_SHORTFMT = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;
    fmt_t        pend_reg, pend_next;
    fmt_t        kept_reg, kept_next;
    logic [31:0] kbytes_reg, kbytes_next;
    logic        ffmt_reg, ffmt_next;
    logic        fdata_reg, fdata_next;
    logic        mism_reg, mism_next;
    logic [7:0]  low_reg, low_next;
    logic        par_reg, par_next;

    logic [7:0]  b;
    logic [31:0] off;
    logic [31:0] left_dec;
    logic        done;

    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        kept_next   = kept_reg;
        kbytes_next = kbytes_reg;
        ffmt_next   = ffmt_reg;
        fdata_next  = fdata_reg;
        mism_next   = mism_reg;
        low_next    = low_reg;
        par_next    = par_reg;
        cmd         = '0;
        done        = 1'b0;
        b           = item.in_byte;
        off         = len_reg - left_reg;
        left_dec    = left_reg - 32'd1;

        unique case (phase_reg)
            PH_HDR: begin
                if ((idx_reg < 4'd4 || idx_reg > 4'd7) && idx_reg <= HDR_LAST &&
                    b != sig_byte(idx_reg)) begin
                    mism_next = 1'b1;
                end
                if (idx_reg >= HDR_LAST) begin
                    idx_next   = '0;
                    phase_next = mism_next ? PH_BADSIG : PH_CHDR;
                end else begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            PH_CHDR: begin
                if (!idx_reg[2]) begin
                    id_next[{idx_reg[1:0], 3'b000} +: 8] = b;
                end else begin
                    len_next[{idx_reg[1:0], 3'b000} +: 8] = b;
                end
                if (idx_reg[2:0] == CHDR_LAST) begin
                    idx_next  = '0;
                    left_next = len_next;
                    par_next  = 1'b0;
                    if (len_next == '0) begin
                        done = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end else begin
                    idx_next = {1'b0, idx_reg[2:0] + 3'd1};
                end
            end
            PH_BODY: begin
                if (id_reg == FMT_ID && off < FMT_MIN) begin
                    case (off[3:0])
                        4'd0:    pend_next.format[7:0]    = b;
                        4'd1:    pend_next.format[15:8]   = b;
                        4'd2:    pend_next.channels[7:0]  = b;
                        4'd3:    pend_next.channels[15:8] = b;
                        4'd4:    pend_next.rate[7:0]      = b;
                        4'd5:    pend_next.rate[15:8]     = b;
                        4'd6:    pend_next.rate[23:16]    = b;
                        4'd7:    pend_next.rate[31:24]    = b;
                        4'd14:   pend_next.bits[7:0]      = b;
                        4'd15:   pend_next.bits[15:8]     = b;
                        default: ;
                    endcase
                end
                if (id_reg == DATA_ID) begin
                    if (par_reg) begin
                        cmd.has_smp     = 1'b1;
                        cmd.sample      = {b, low_reg};
                        cmd.chunk_start = (off == 32'd1);
                        cmd.smp_last    = !item.in_last;
                        par_next        = 1'b0;
                    end else begin
                        low_next = b;
                        par_next = 1'b1;
                    end
                end
                left_next = left_dec;
                if (left_dec == '0) begin
                    done = 1'b1;
                end
            end
            PH_PAD: begin
                idx_next   = '0;
                phase_next = PH_CHDR;
            end
            default: ;
        endcase

        if (done) begin
            if (id_next == FMT_ID && len_next < FMT_MIN) begin
                phase_next = PH_SHORTFMT;
            end else begin
                if (id_next == FMT_ID) begin
                    kept_next = pend_next;
                    ffmt_next = 1'b1;
                end else if (id_next == DATA_ID) begin
                    kbytes_next = len_next;
                    fdata_next  = 1'b1;
                end
                idx_next   = '0;
                phase_next = len_next[0] ? PH_PAD : PH_CHDR;
            end
        end

        if (item.in_last) begin
            cmd.has_rep = 1'b1;
            if (phase_next == PH_HDR || phase_next == PH_BADSIG) begin
                cmd.status = ST_NO_RIFF;
            end else if (phase_next == PH_SHORTFMT) begin
                cmd.status = ST_SHORT_FMT;
            end else if (!(ffmt_next && fdata_next)) begin
                cmd.status = ST_MISSING;
            end else if (kept_next.format != FMT_PCM) begin
                cmd.status = ST_NOT_PCM;
            end else if (kept_next.bits != BITS_16) begin
                cmd.status = ST_NOT_16BIT;
            end else if (kbytes_next[31:1] == '0) begin
                cmd.status = ST_EMPTY;
            end else if (kept_next.channels == '0) begin
                cmd.status = ST_ZERO_CH;
            end else begin
                cmd.status        = ST_OK;
                cmd.channel_count = kept_next.channels;
                cmd.sample_rate   = kept_next.rate;
                cmd.numer         = kbytes_next[31:1];
            end
            phase_next  = PH_HDR;
            idx_next    = '0;
            id_next     = '0;
            len_next    = '0;
            left_next   = '0;
            pend_next   = '0;
            kept_next   = '0;
            kbytes_next = '0;
            ffmt_next   = 1'b0;
            fdata_next  = 1'b0;
            mism_next   = 1'b0;
            low_next    = '0;
            par_next    = 1'b0;
        end
    end

    assign push = accept && (cmd.has_smp || cmd.has_rep);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR;
            idx_reg    <= '0;
            id_reg     <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            pend_reg   <= '0;
            kept_reg   <= '0;
            kbytes_reg <= '0;
            ffmt_reg   <= 1'b0;
            fdata_reg  <= 1'b0;
            mism_reg   <= 1'b0;
            low_reg    <= '0;
            par_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            kept_reg   <= kept_next;
            kbytes_reg <= kbytes_next;
            ffmt_reg   <= ffmt_next;
            fdata_reg  <= fdata_next;
            mism_reg   <= mism_next;
            low_reg    <= low_next;
            par_reg    <= par_next;
        end
    end

endmodule

[rtl/core/wps_fifo.sv]
module wps_fifo import wps_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty,
    output logic full
);

    cmd_t             mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCW'(QDEPTH));
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCW'(1);
            end
        end
    end

endmodule

[rtl/core/wps_back.sv]
module wps_back import wps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_SMP  = 4'b0010,
        B_DIV  = 4'b0100,
        B_REP  = 4'b1000
    } bstate_t;

    bstate_t          state_reg, state_next;
    cmd_t             ent_reg;
    logic [15:0]      rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    out_item_t        m_item_reg;

    logic             out_free;
    logic [16:0]      shifted;
    logic             ge;
    logic             load_smp;
    logic             load_rep;
    out_item_t        smp_item;
    out_item_t        rep_item;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign shifted  = {rem_reg, quo_reg[QUO_W-1]};
    assign ge       = (shifted >= {1'b0, ent_reg.channel_count});
    assign load_smp = (state_reg == B_SMP) && out_free;
    assign load_rep = (state_reg == B_REP) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    if (q_cmd.has_smp) begin
                        state_next = B_SMP;
                    end else begin
                        state_next = (q_cmd.status == ST_OK) ? B_DIV : B_REP;
                    end
                end
            end
            B_SMP: begin
                if (out_free) begin
                    if (!ent_reg.has_rep) begin
                        state_next = B_IDLE;
                    end else begin
                        state_next = (ent_reg.status == ST_OK) ? B_DIV : B_REP;
                    end
                end
            end
            B_DIV: begin
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    state_next = B_REP;
                end
            end
            B_REP: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        smp_item               = '0;
        smp_item.out_kind      = KIND_SAMPLE;
        smp_item.sample        = ent_reg.sample;
        smp_item.chunk_start   = ent_reg.chunk_start;
        smp_item.last          = ent_reg.smp_last;

        rep_item               = '0;
        rep_item.out_kind      = KIND_REPORT;
        rep_item.status        = ent_reg.status;
        rep_item.channel_count = ent_reg.channel_count;
        rep_item.sample_rate   = ent_reg.sample_rate;
        rep_item.frame_count   = (ent_reg.status == ST_OK) ? quo_reg : '0;
        rep_item.last          = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_cmd;
            quo_reg <= q_cmd.numer;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (state_reg == B_DIV) begin
            rem_reg <= ge ? 16'(shifted - {1'b0, ent_reg.channel_count}) : shifted[15:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_smp) begin
            m_item_reg <= smp_item;
        end else if (load_rep) begin
            m_item_reg <= rep_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_smp || load_rep) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[rtl/core/wav_pcm16_stream_parser_top.sv]
// Path: a sample passes the command queue, the back-end entry register and the output
//   register once its high byte is accepted; the report of a good file also waits for
//   the bit-serial frame divider.
// Throughput: one byte per cycle while the 4-entry command queue has room; the back end
//   pops a queue entry only when idle, after handing the last one to the output register.
// Reset: synchronous, active-low aresetn clears parser, queue pointers and output valid.
//   After each report the parser is back in its header phase for the next file.
module wav_pcm16_stream_parser_top import wps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t pop_cmd;
    logic q_empty;
    logic q_full;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    wps_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_item),
        .push    (push),
        .cmd     (push_cmd)
    );

    wps_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    wps_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_cmd   (pop_cmd),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

[rtl/core/wps_checker.sv]
module wps_checker import wps_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input transfer dropped while stalled");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_sample_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.out_kind == KIND_SAMPLE |->
            m_item.status == ST_OK && m_item.channel_count == '0 &&
            m_item.sample_rate == '0 && m_item.frame_count == '0)
        else $error("sample transfer carries report fields");

    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.out_kind == KIND_REPORT |->
            m_item.last && m_item.sample == '0 && !m_item.chunk_start)
        else $error("report transfer malformed");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.out_kind == KIND_REPORT && m_item.status != ST_OK |->
            m_item.channel_count == '0 && m_item.sample_rate == '0 &&
            m_item.frame_count == '0)
        else $error("error report carries format fields");

endmodule

bind wav_pcm16_stream_parser_top wps_checker u_wps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

[tb/sv/tb_wav_pcm16_stream_parser_top.sv]
module tb_wav_pcm16_stream_parser_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wps_pkg::*;

    localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
    localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
    localparam logic [31:0] RIFX_TAG = 32'h5846_4952;
    localparam logic [31:0] LIST_TAG = 32'h5453_494c;
    localparam int RANDOM_BYTES_PER_PHASE = 210;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [2:0] {
        WAV_HEADER,
        CHUNK_HEADER,
        CHUNK_BODY,
        CHUNK_PAD,
        SKIP_BAD_SIG,
        SKIP_SHORT_FMT
    } wav_phase_e;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    wav_phase_e  wav_phase;
    logic [3:0]  field_idx;
    logic [31:0] chunk_id;
    logic [31:0] chunk_len;
    logic [31:0] body_left;
    logic [31:0] kept_data_len;
    fmt_t        pend_fmt;
    fmt_t        kept_fmt;
    logic        fmt_seen;
    logic        data_seen;
    logic        sig_bad;
    logic [7:0]  low_hold;
    logic        low_held;

    out_item_t  pending_results[$];
    logic [7:0] wav_bytes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int bytes_sent;
    int files_sent;
    int samples_seen;
    int reports_seen;

    wav_pcm16_stream_parser_top i_dut (
        .aclk,
        .aresetn,
        .s_valid,
        .s_ready,
        .s_item,
        .m_valid,
        .m_ready,
        .m_item
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void clear_parser();
        wav_phase = WAV_HEADER;
        field_idx = '0;
        chunk_id = '0;
        chunk_len = '0;
        body_left = '0;
        kept_data_len = '0;
        pend_fmt = '0;
        kept_fmt = '0;
        fmt_seen = 1'b0;
        data_seen = 1'b0;
        sig_bad = 1'b0;
        low_hold = '0;
        low_held = 1'b0;
    endfunction

    function automatic void close_chunk();
        if (chunk_id == FMT_ID) begin
            if (chunk_len < FMT_MIN) begin
                wav_phase = SKIP_SHORT_FMT;
                return;
            end
            kept_fmt = pend_fmt;
            fmt_seen = 1'b1;
        end else if (chunk_id == DATA_ID) begin
            kept_data_len = chunk_len;
            data_seen = 1'b1;
        end
        field_idx = '0;
        wav_phase = chunk_len[0] ? CHUNK_PAD : CHUNK_HEADER;
    endfunction

    function automatic void parse_wav_byte(input logic [7:0] b, input logic is_last);
        int          i;
        logic [31:0] off;
        logic [30:0] half_len;
        out_item_t   r;
        case (wav_phase)
            WAV_HEADER: begin
                i = field_idx;
                if ((i < 4 && b != RIFF_TAG[8*i +: 8]) ||
                    (i >= 8 && b != WAVE_TAG[8*(i-8) +: 8]))
                    sig_bad = 1'b1;
                if (i == 11) begin
                    field_idx = '0;
                    wav_phase = sig_bad ? SKIP_BAD_SIG : CHUNK_HEADER;
                end else begin
                    field_idx = field_idx + 1'b1;
                end
            end
            CHUNK_HEADER: begin
                i = field_idx[2:0];
                if (i < 4)
                    chunk_id[8*i +: 8] = b;
                else
                    chunk_len[8*(i-4) +: 8] = b;
                if (i == 7) begin
                    field_idx = '0;
                    body_left = chunk_len;
                    low_held = 1'b0;
                    if (chunk_len == 0)
                        close_chunk();
                    else
                        wav_phase = CHUNK_BODY;
                end else begin
                    field_idx = field_idx + 1'b1;
                end
            end
            CHUNK_BODY: begin
                off = chunk_len - body_left;
                if (chunk_id == FMT_ID && off < FMT_MIN) begin
                    case (off)
                        0, 1:       pend_fmt.format[8*off +: 8] = b;
                        2, 3:       pend_fmt.channels[8*(off-2) +: 8] = b;
                        4, 5, 6, 7: pend_fmt.rate[8*(off-4) +: 8] = b;
                        14, 15:     pend_fmt.bits[8*(off-14) +: 8] = b;
                        default: ;
                    endcase
                end
                if (chunk_id == DATA_ID) begin
                    if (low_held) begin
                        r = '0;
                        r.out_kind = KIND_SAMPLE;
                        r.sample = {b, low_hold};
                        r.chunk_start = (off == 1);
                        r.last = !is_last;
                        pending_results.push_back(r);
                        low_held = 1'b0;
                    end else begin
                        low_hold = b;
                        low_held = 1'b1;
                    end
                end
                body_left = body_left - 1;
                if (body_left == 0)
                    close_chunk();
            end
            CHUNK_PAD: begin
                field_idx = '0;
                wav_phase = CHUNK_HEADER;
            end
            default: ;
        endcase

        if (is_last) begin
            r = '0;
            r.out_kind = KIND_REPORT;
            r.last = 1'b1;
            half_len = kept_data_len[31:1];
            if (wav_phase == WAV_HEADER || wav_phase == SKIP_BAD_SIG)
                r.status = ST_NO_RIFF;
            else if (wav_phase == SKIP_SHORT_FMT)
                r.status = ST_SHORT_FMT;
            else if (!(fmt_seen && data_seen))
                r.status = ST_MISSING;
            else if (kept_fmt.format != FMT_PCM)
                r.status = ST_NOT_PCM;
            else if (kept_fmt.bits != BITS_16)
                r.status = ST_NOT_16BIT;
            else if (half_len == 0)
                r.status = ST_EMPTY;
            else if (kept_fmt.channels == 0)
                r.status = ST_ZERO_CH;
            else begin
                r.status = ST_OK;
                r.channel_count = kept_fmt.channels;
                r.sample_rate = kept_fmt.rate;
                r.frame_count = half_len / kept_fmt.channels;
            end
            pending_results.push_back(r);
            clear_parser();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_item.out_kind == KIND_REPORT)
                reports_seen++;
            else
                samples_seen++;
            if (pending_results.size() == 0) begin
                $display("%t: unexpected result, expected none, got %h", $time, m_item);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_kind", want.out_kind, m_item.out_kind);
                check_field("sample", want.sample, m_item.sample);
                check_field("chunk_start", want.chunk_start, m_item.chunk_start);
                check_field("status", want.status, m_item.status);
                check_field("channel_count", want.channel_count, m_item.channel_count);
                check_field("sample_rate", want.sample_rate, m_item.sample_rate);
                check_field("frame_count", want.frame_count, m_item.frame_count);
                check_field("last", want.last, m_item.last);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= '{in_byte: b, in_last: is_last};
        do @(posedge aclk); while (!s_ready);
        parse_wav_byte(b, is_last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_file();
        foreach (wav_bytes[k])
            send_byte(wav_bytes[k], k == wav_bytes.size() - 1);
        files_sent++;
        wav_bytes.delete();
    endtask

    function automatic void push_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            wav_bytes.push_back(v[8*k +: 8]);
    endfunction

    function automatic void push_chunk_hdr(input logic [31:0] id, input logic [31:0] len);
        push_le(id, 4);
        push_le(len, 4);
    endfunction

    function automatic void push_riff_header();
        push_le(RIFF_TAG, 4);
        push_le($urandom, 4);
        push_le(WAVE_TAG, 4);
    endfunction

    function automatic void push_chunk(input logic [31:0] id, input logic [31:0] len);
        push_chunk_hdr(id, len);
        repeat (len) wav_bytes.push_back(8'($urandom));
        if (len[0])
            wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void push_fmt_chunk(input logic [15:0] format,
                                           input logic [15:0] channels,
                                           input logic [31:0] rate,
                                           input logic [15:0] bits,
                                           input logic [31:0] len);
        logic [7:0] v;
        push_chunk_hdr(FMT_ID, len);
        for (int off = 0; off < len; off++) begin
            case (off)
                0, 1:       v = format[8*off +: 8];
                2, 3:       v = channels[8*(off-2) +: 8];
                4, 5, 6, 7: v = rate[8*(off-4) +: 8];
                14, 15:     v = bits[8*(off-14) +: 8];
                default:    v = 8'($urandom);
            endcase
            wav_bytes.push_back(v);
        end
        if (len[0])
            wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void cut_file(input int keep);
        while (wav_bytes.size() > keep)
            void'(wav_bytes.pop_back());
    endfunction

    task automatic test_good_files();
        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, BITS_16, 32'd16);
        push_chunk_hdr(DATA_ID, 32'd8);
        push_le(32'h7fff_8000, 4);
        push_le(32'hffff_0000, 4);
        send_file();

        push_riff_header();
        push_chunk(LIST_TAG, 32'd3);
        push_fmt_chunk(FMT_PCM, 16'hffff, 32'hffff_ffff, BITS_16, 32'd18);
        push_chunk(DATA_ID, 32'd7);
        send_file();

        // later chunks win; end the file where the pad byte is due
        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd3, 32'd8000, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd4);
        push_chunk(DATA_ID, 32'd6);
        push_fmt_chunk(FMT_PCM, 16'd1, 32'd48000, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd5);
        cut_file(wav_bytes.size() - 1);
        send_file();
    endtask

    task automatic test_header_errors();
        push_le(RIFF_TAG, 4);
        push_le(32'd0, 1);
        send_file();

        push_riff_header();
        send_file();

        push_le(RIFX_TAG, 4);
        push_le($urandom, 4);
        push_le(WAVE_TAG, 4);
        push_fmt_chunk(FMT_PCM, 16'd1, 32'd22050, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd4);
        send_file();

        push_riff_header();
        wav_bytes[11] = 8'h46;
        push_fmt_chunk(FMT_PCM, 16'd1, 32'd22050, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd4);
        send_file();
    endtask

    task automatic test_format_errors();
        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, BITS_16, 32'd14);
        push_chunk(DATA_ID, 32'd4);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, BITS_16, 32'd0);
        push_chunk(DATA_ID, 32'd4);
        send_file();

        push_riff_header();
        push_fmt_chunk(16'd3, 16'd0, 32'd44100, 16'd8, 32'd16);
        push_chunk(DATA_ID, 32'd4);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, 16'd8, 32'd16);
        push_chunk(DATA_ID, 32'd4);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd1);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd0);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd0, 32'd44100, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd4);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd44100, BITS_16, 32'd16);
        send_file();

        push_riff_header();
        push_chunk(DATA_ID, 32'd6);
        send_file();
    endtask

    task automatic test_truncation();
        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd1, 32'd16000, BITS_16, 32'd16);
        push_chunk_hdr(DATA_ID, 32'hffff_fff0);
        push_le($urandom, 4);
        push_le($urandom, 3);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd16000, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd8);
        push_chunk_hdr(DATA_ID, 32'd20);
        push_le($urandom, 4);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd1, 32'd11025, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd6);
        push_le(FMT_ID, 3);
        send_file();

        push_riff_header();
        push_fmt_chunk(FMT_PCM, 16'd2, 32'd96000, BITS_16, 32'd16);
        push_chunk(DATA_ID, 32'd8);
        push_fmt_chunk(FMT_PCM, 16'd5, 32'd8000, BITS_16, 32'd16);
        cut_file(wav_bytes.size() - 6);
        send_file();
    endtask

    task automatic test_random_files(input int idle_pct, input int stall_pct);
        int start;
        int pick;
        int nchunks;
        int len;
        bit stop;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES_PER_PHASE) begin
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(1, 24)) wav_bytes.push_back(8'($urandom));
            end else begin
                push_riff_header();
                if ($urandom_range(99) < 5)
                    wav_bytes[$urandom_range(11)] ^= 8'($urandom_range(1, 255));
                stop = 1'b0;
                nchunks = $urandom_range(0, 4);
                for (int c = 0; c < nchunks && !stop; c++) begin
                    pick = $urandom_range(99);
                    if (pick < 40) begin
                        len = ($urandom_range(99) < 80) ? 16 : $urandom_range(0, 24);
                        push_fmt_chunk(($urandom_range(99) < 85) ? FMT_PCM : 16'($urandom),
                                       ($urandom_range(99) < 85) ? 16'($urandom_range(1, 8)) :
                                       ($urandom_range(1) ? 16'd0 : 16'($urandom)),
                                       $urandom,
                                       ($urandom_range(99) < 85) ? BITS_16 : 16'($urandom),
                                       len);
                    end else if (pick < 80) begin
                        if ($urandom_range(99) < 8) begin
                            // cut a huge data chunk short and end the file there
                            push_chunk_hdr(DATA_ID, $urandom | 32'h40);
                            repeat ($urandom_range(0, 12)) wav_bytes.push_back(8'($urandom));
                            stop = 1'b1;
                        end else begin
                            push_chunk(DATA_ID, ($urandom_range(99) < 85) ?
                                       $urandom_range(0, 16) : $urandom_range(17, 40));
                        end
                    end else begin
                        push_chunk($urandom, $urandom_range(0, 6));
                    end
                end
                if (!stop && $urandom_range(99) < 10)
                    cut_file($urandom_range(1, wav_bytes.size()));
            end
            send_file();
        end
    endtask

    initial begin
        int waited;
        clear_parser();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_good_files();
        test_header_errors();
        test_format_errors();
        test_truncation();
        test_random_files(0, 0);
        test_random_files(70, 0);
        test_random_files(0, 70);
        test_random_files(29, 29);
        s_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%t: %0d expected results never arrived", $time, pending_results.size());
            mismatch_count++;
        end

        $display("Parsed %0d WAV files (%0d bytes): %0d samples, %0d status reports checked",
                 files_sent, bytes_sent, samples_seen, reports_seen);
        $display("Idling: none, sender 70%%, receiver 70%%, both 29%%");
        if (mismatch_count == 0) begin
            $display("tb_wav_pcm16_stream_parser_top OK");
        end else begin
            $display("tb_wav_pcm16_stream_parser_top NOT OK");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("tb_wav_pcm16_stream_parser_top NOT OK");
        $finish;
    end

endmodule
